[hw/rtl/dpdw_pkg.sv]
// Shared constants, types and arithmetic helpers for the DPD wall dissipative force unit.
`default_nettype none

package dpdw_pkg;

   localparam int FRAC_BITS = 16;

   localparam int PW  = 66;
   localparam int ZW  = FRAC_BITS + 2;
   localparam int UW  = FRAC_BITS + 3;
   localparam int U2W = FRAC_BITS + 4;
   localparam int U4W = FRAC_BITS + 6;
   localparam int U5W = FRAC_BITS + 7;
   localparam int QW  = FRAC_BITS + 5;
   localparam int RW  = FRAC_BITS + 3;
   localparam int WW  = FRAC_BITS + 9;

   localparam longint ONE_Q  = longint'(1) << FRAC_BITS;
   localparam longint HALF_Q = longint'(1) << (FRAC_BITS - 1);

   localparam logic signed [PW-1:0] HALF_P   = PW'(HALF_Q);
   localparam logic signed [PW-1:0] S32_MAX_P = PW'(longint'(64'h0000_0000_7FFF_FFFF));
   localparam logic signed [PW-1:0] S32_MIN_P = PW'(-longint'(64'h0000_0000_8000_0000));
   localparam logic [61:0] HALF_U62 = 62'(HALF_Q);
   localparam logic [61:0] U31_MAX  = 62'(32'h7FFF_FFFF);

   // Reciprocal of three for a 29-bit dividend, exact with a 31-bit shift.
   localparam logic [29:0] DIV3_K = 30'd715827883;
   localparam int DIV3_SHIFT = 31;

   typedef logic signed [31:0] q32_type;

   typedef enum logic [1:0] {
      AXIS_X    = 2'd0,
      AXIS_Y    = 2'd1,
      AXIS_Z    = 2'd2,
      AXIS_NONE = 2'd3
   } axis_type;

   typedef enum logic [2:0] {
      CSR_WALL_AXIS         = 3'd0,
      CSR_LEFT_WALL_POS     = 3'd1,
      CSR_RIGHT_WALL_POS    = 3'd2,
      CSR_CUTOFF_DIST       = 3'd3,
      CSR_RECIP_CUTOFF      = 3'd4,
      CSR_DISSIPATION_CONST = 3'd5,
      CSR_WALL_DENSITY      = 3'd6
   } csr_index_type;

   typedef struct packed {
      axis_type          wall_axis;
      logic signed [31:0] left_wall_pos;
      logic signed [31:0] right_wall_pos;
      logic [30:0]       cutoff_dist;
      logic [30:0]       recip_cutoff;
      logic [30:0]       dissipation_const;
      logic [30:0]       wall_density;
   } cfg_type;

   localparam logic signed [31:0] LEFT_WALL_RESET  = 32'(-(longint'(10) << FRAC_BITS));
   localparam logic signed [31:0] RIGHT_WALL_RESET = 32'(longint'(10) << FRAC_BITS);
   localparam logic [30:0]        ONE_RESET_31     = 31'(ONE_Q);

   function automatic logic signed [PW-1:0] rnd_q(input logic signed [PW-1:0] p);
      return (p + HALF_P) >>> FRAC_BITS;
   endfunction

   function automatic logic [30:0] usat31(input logic [61:0] p);
      logic [61:0] s;
      s = (p + HALF_U62) >> FRAC_BITS;
      return (s > U31_MAX) ? 31'h7FFF_FFFF : s[30:0];
   endfunction

   function automatic logic signed [31:0] ssat32(input logic signed [PW-1:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX_P) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < S32_MIN_P) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/dpd_wall_dissipative_force_unit.sv]
// Top level of the DPD flat-wall dissipative force unit: eight-stage force pipeline.
//
// Each transfer on the req_ channel carries one particle's position and velocity
// (signed Q16.16). Each transfer on the rsp_ channel returns in_band and the three
// force increments, in the order the particles came in, one result per particle.
// The csr_ port writes the wall axis, wall positions, cutoff, reciprocal cutoff,
// dissipation constant and wall density; write it only while no particle is in flight.
// An item accepted at a clock edge is held in eight register stages: the first
// selects the wall and distance, then come the scaled distance, the polynomial
// terms and velocity factor, the two weights and the two output multiplies. Its
// result is presented from the eighth stage, where rsp_valid shows it.
// With rsp_stall low the unit takes one particle every cycle. Each stage holds
// only while the stage after it is full and held, so empty stages close up and
// req_stall rises only when all eight stages are full and rsp_stall is high.
// Reset empties the pipeline and restores the configuration reset values.
`default_nettype none

module dpd_wall_dissipative_force_unit
   import dpdw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_pos_x,
   input  wire logic [31:0] req_pos_y,
   input  wire logic [31:0] req_pos_z,
   input  wire logic [31:0] req_vel_x,
   input  wire logic [31:0] req_vel_y,
   input  wire logic [31:0] req_vel_z,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_in_band,
   output logic [31:0]      rsp_force_x,
   output logic [31:0]      rsp_force_y,
   output logic [31:0]      rsp_force_z,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int NST = 8;

   cfg_type cfg;

   dpdw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;
   logic [NST-1:0] en;

   always_comb begin
      en[NST-1] = !vld_ff[NST-1] || !rsp_stall;
      for (int k = NST - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign vld_in = {vld_ff[NST-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= (en & vld_in) | (~en & vld_ff);
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = vld_ff[NST-1];

   // Stage 1: wall selection and signed distance.
   q32_type            req_vel [3];
   logic signed [32:0] p33, left33, right33, cut33, lc33, rc33;
   logic               s1_near_in, below_left;
   logic signed [32:0] s1_dist_in;

   logic               s1_near_ff;
   logic signed [32:0] s1_dist_ff;
   q32_type            s1_vel_ff [3];

   assign req_vel[0] = req_vel_x;
   assign req_vel[1] = req_vel_y;
   assign req_vel[2] = req_vel_z;

   always_comb begin
      case (cfg.wall_axis)
         AXIS_X:  p33 = 33'($signed(req_pos_x));
         AXIS_Y:  p33 = 33'($signed(req_pos_y));
         AXIS_Z:  p33 = 33'($signed(req_pos_z));
         default: p33 = 33'($signed(req_pos_x));
      endcase
      left33     = 33'(cfg.left_wall_pos);
      right33    = 33'(cfg.right_wall_pos);
      cut33      = $signed({2'b00, cfg.cutoff_dist});
      lc33       = left33 + cut33;
      rc33       = right33 - cut33;
      below_left = p33 < lc33;
      s1_near_in = (cfg.wall_axis != AXIS_NONE) && (below_left || (p33 > rc33));
      s1_dist_in = below_left ? (p33 - left33) : (right33 - p33);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_near_ff <= s1_near_in;
         s1_dist_ff <= s1_dist_in;
         s1_vel_ff  <= req_vel;
      end
   end

   // Stage 2: scaled distance and the two configuration products.
   logic signed [PW-1:0] zp_raw;
   logic signed [ZW-1:0] s2_zp_in;
   logic [30:0]          s2_a_in, s2_b_in;

   logic                 s2_near_ff;
   logic signed [ZW-1:0] s2_zp_ff;
   logic [30:0]          s2_a_ff, s2_b_ff;
   q32_type              s2_vel_ff [3];

   always_comb begin
      zp_raw = rnd_q(PW'(s1_dist_ff) * PW'($signed({1'b0, cfg.recip_cutoff})));
      if (zp_raw > PW'(ONE_Q)) begin
         s2_zp_in = ZW'(ONE_Q);
      end else if (zp_raw < PW'(-ONE_Q)) begin
         s2_zp_in = ZW'(-ONE_Q);
      end else begin
         s2_zp_in = zp_raw[ZW-1:0];
      end
      s2_a_in = usat31(62'(cfg.dissipation_const) * 62'(cfg.wall_density));
      s2_b_in = usat31(62'(cfg.cutoff_dist) * 62'(cfg.cutoff_dist));
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_near_ff <= s1_near_ff;
         s2_zp_ff   <= s2_zp_in;
         s2_a_ff    <= s2_a_in;
         s2_b_ff    <= s2_b_in;
         s2_vel_ff  <= s1_vel_ff;
      end
   end

   // Stage 3: u = 1 - zp, u^2, zp^2 and the combined constant.
   logic signed [UW-1:0]  s3_u_in;
   logic signed [PW-1:0]  u2_raw, zz_raw;
   logic signed [U2W-1:0] s3_u2_in;
   logic signed [ZW-1:0]  s3_zz_in;
   logic [30:0]           s3_c_in;

   logic                  s3_near_ff;
   logic signed [ZW-1:0]  s3_zp_ff, s3_zz_ff;
   logic signed [UW-1:0]  s3_u_ff;
   logic signed [U2W-1:0] s3_u2_ff;
   logic [30:0]           s3_c_ff;
   q32_type               s3_vel_ff [3];

   always_comb begin
      s3_u_in  = UW'(ONE_Q) - UW'(s2_zp_ff);
      u2_raw   = rnd_q(PW'(s3_u_in) * PW'(s3_u_in));
      zz_raw   = rnd_q(PW'(s2_zp_ff) * PW'(s2_zp_ff));
      s3_u2_in = u2_raw[U2W-1:0];
      s3_zz_in = zz_raw[ZW-1:0];
      s3_c_in  = usat31(62'(s2_a_ff) * 62'(s2_b_ff));
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_near_ff <= s2_near_ff;
         s3_zp_ff   <= s2_zp_ff;
         s3_zz_ff   <= s3_zz_in;
         s3_u_ff    <= s3_u_in;
         s3_u2_ff   <= s3_u2_in;
         s3_c_ff    <= s3_c_in;
         s3_vel_ff  <= s2_vel_ff;
      end
   end

   // Stage 4: u^4, the two polynomial sums and the velocity factor.
   logic signed [PW-1:0]  u4_raw;
   logic signed [U4W-1:0] s4_u4_in;
   logic signed [QW-1:0]  s4_q_in, zz_q;
   logic signed [RW-1:0]  s4_r_in;
   logic [59:0]           div3_prod;
   logic signed [31:0]    s4_factor_in;

   logic                  s4_near_ff;
   logic signed [UW-1:0]  s4_u_ff;
   logic signed [U4W-1:0] s4_u4_ff;
   logic signed [QW-1:0]  s4_q_ff;
   logic signed [RW-1:0]  s4_r_ff;
   logic signed [31:0]    s4_factor_ff;
   q32_type               s4_vel_ff [3];

   always_comb begin
      u4_raw       = rnd_q(PW'(s3_u2_ff) * PW'(s3_u2_ff));
      s4_u4_in     = u4_raw[U4W-1:0];
      zz_q         = QW'(s3_zz_ff);
      s4_q_in      = QW'(ONE_Q) + (QW'(s3_zp_ff) <<< 2) + (zz_q <<< 3) + (zz_q <<< 1);
      s4_r_in      = RW'(ONE_Q) + (RW'(s3_zp_ff) <<< 1);
      div3_prod    = 60'(s3_c_ff[30:2]) * 60'(DIV3_K);
      s4_factor_in = -$signed({3'b000, div3_prod[DIV3_SHIFT+28:DIV3_SHIFT]});
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s4_near_ff   <= s3_near_ff;
         s4_u_ff      <= s3_u_ff;
         s4_u4_ff     <= s4_u4_in;
         s4_q_ff      <= s4_q_in;
         s4_r_ff      <= s4_r_in;
         s4_factor_ff <= s4_factor_in;
         s4_vel_ff    <= s3_vel_ff;
      end
   end

   // Stage 5: u^5 and the perpendicular weight.
   logic signed [PW-1:0]  u5_raw, perp_raw;
   logic signed [U5W-1:0] s5_u5_in;
   logic signed [WW-1:0]  s5_perp_in;

   logic                  s5_near_ff;
   logic signed [U5W-1:0] s5_u5_ff;
   logic signed [WW-1:0]  s5_perp_ff;
   logic signed [RW-1:0]  s5_r_ff;
   logic signed [31:0]    s5_factor_ff;
   q32_type               s5_vel_ff [3];

   always_comb begin
      u5_raw     = rnd_q(PW'(s4_u4_ff) * PW'(s4_u_ff));
      perp_raw   = rnd_q(PW'(s4_u4_ff) * PW'(s4_q_ff));
      s5_u5_in   = u5_raw[U5W-1:0];
      s5_perp_in = perp_raw[WW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s5_near_ff   <= s4_near_ff;
         s5_u5_ff     <= s5_u5_in;
         s5_perp_ff   <= s5_perp_in;
         s5_r_ff      <= s4_r_ff;
         s5_factor_ff <= s4_factor_ff;
         s5_vel_ff    <= s4_vel_ff;
      end
   end

   // Stage 6: the parallel weight.
   logic signed [PW-1:0] par_raw;
   logic signed [WW-1:0] s6_par_in;

   logic                 s6_near_ff;
   logic signed [WW-1:0] s6_perp_ff, s6_par_ff;
   logic signed [31:0]   s6_factor_ff;
   q32_type              s6_vel_ff [3];

   always_comb begin
      par_raw   = rnd_q(PW'(s5_u5_ff) * PW'(s5_r_ff));
      s6_par_in = par_raw[WW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s6_near_ff   <= s5_near_ff;
         s6_perp_ff   <= s5_perp_ff;
         s6_par_ff    <= s6_par_in;
         s6_factor_ff <= s5_factor_ff;
         s6_vel_ff    <= s5_vel_ff;
      end
   end

   // Stage 7: per-axis gain, one lane per axis.
   q32_type s7_g_in [3];

   logic    s7_near_ff;
   q32_type s7_g_ff [3];
   q32_type s7_vel_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s7_g_in[i] = ssat32(rnd_q(PW'(s6_factor_ff) *
                      PW'((2'(i) == cfg.wall_axis) ? s6_perp_ff : s6_par_ff)));
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s7_near_ff <= s6_near_ff;
         s7_g_ff    <= s7_g_in;
         s7_vel_ff  <= s6_vel_ff;
      end
   end

   // Stage 8: force per axis, forced to zero away from the walls.
   q32_type s8_force_in [3];

   logic    s8_near_ff;
   q32_type s8_force_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s8_force_in[i] = s7_near_ff ? ssat32(rnd_q(PW'(s7_g_ff[i]) * PW'(s7_vel_ff[i])))
                                     : 32'sd0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         s8_near_ff  <= s7_near_ff;
         s8_force_ff <= s8_force_in;
      end
   end

   assign rsp_in_band = s8_near_ff;
   assign rsp_force_x = s8_force_ff[0];
   assign rsp_force_y = s8_force_ff[1];
   assign rsp_force_z = s8_force_ff[2];

   // An input transfer always lands in the first stage.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[0])
      else $error("accepted item did not enter the first stage");

   // The input side only stalls when every stage is full.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&vld_ff) && rsp_stall)
      else $error("input stalled while the pipeline had room");

   // A result away from the walls carries no force.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_band |->
         rsp_force_x == 32'd0 && rsp_force_y == 32'd0 && rsp_force_z == 32'd0)
      else $error("nonzero force on a particle away from the walls");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

[hw/rtl/dpdw_csr.sv]
// Configuration register file for the DPD wall dissipative force unit.
`default_nettype none

module dpdw_csr
   import dpdw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_WALL_AXIS:         cfg_in.wall_axis         = axis_type'(csr_wdata[1:0]);
            CSR_LEFT_WALL_POS:     cfg_in.left_wall_pos     = csr_wdata;
            CSR_RIGHT_WALL_POS:    cfg_in.right_wall_pos    = csr_wdata;
            CSR_CUTOFF_DIST:       cfg_in.cutoff_dist       = csr_wdata[30:0];
            CSR_RECIP_CUTOFF:      cfg_in.recip_cutoff      = csr_wdata[30:0];
            CSR_DISSIPATION_CONST: cfg_in.dissipation_const = csr_wdata[30:0];
            CSR_WALL_DENSITY:      cfg_in.wall_density      = csr_wdata[30:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wall_axis         <= AXIS_X;
         cfg_ff.left_wall_pos     <= LEFT_WALL_RESET;
         cfg_ff.right_wall_pos    <= RIGHT_WALL_RESET;
         cfg_ff.cutoff_dist       <= ONE_RESET_31;
         cfg_ff.recip_cutoff      <= ONE_RESET_31;
         cfg_ff.dissipation_const <= ONE_RESET_31;
         cfg_ff.wall_density      <= ONE_RESET_31;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[bench/dpd_wall_dissipative_force_unit_check.sv]
// Channel monitor that predicts each particle's wall force and compares the results.
module dpd_wall_dissipative_force_unit_check
   import dpdw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [31:0] req_pos_x,
   input  wire logic [31:0] req_pos_y,
   input  wire logic [31:0] req_pos_z,
   input  wire logic [31:0] req_vel_x,
   input  wire logic [31:0] req_vel_y,
   input  wire logic [31:0] req_vel_z,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_in_band,
   input  wire logic [31:0] rsp_force_x,
   input  wire logic [31:0] rsp_force_y,
   input  wire logic [31:0] rsp_force_z,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   output int               mismatch_count,
   output int               pending_count
);

   typedef logic signed [95:0] wide_type;

   typedef struct packed {
      logic        in_band;
      logic [31:0] force_x;
      logic [31:0] force_y;
      logic [31:0] force_z;
   } wall_force_type;

   localparam wide_type ONE_W    = wide_type'(ONE_Q);
   localparam wide_type HALF_W   = wide_type'(HALF_Q);
   localparam wide_type S32_HI_W = 96'sd2147483647;
   localparam wide_type S32_LO_W = -96'sd2147483648;

   axis_type       wall_axis;
   q32_type        left_wall;
   q32_type        right_wall;
   logic [30:0]    cutoff;
   logic [30:0]    recip;
   logic [30:0]    dissipation;
   logic [30:0]    density;
   wall_force_type expected_forces [$];
   int             errors = 0;

   function automatic wide_type round_mul(input wide_type a, input wide_type b);
      return (a * b + HALF_W) >>> FRAC_BITS;
   endfunction

   function automatic wide_type rounded_product_sat31(input wide_type a, input wide_type b);
      wide_type s;
      s = (a * b + HALF_W) >>> FRAC_BITS;
      return (s > S32_HI_W) ? S32_HI_W : s;
   endfunction

   function automatic wide_type clamp_s32(input wide_type v);
      wide_type s;
      s = v;
      if (v > S32_HI_W) begin
         s = S32_HI_W;
      end else if (v < S32_LO_W) begin
         s = S32_LO_W;
      end
      return s;
   endfunction

   function automatic wall_force_type force_for_particle(input logic [2:0][31:0] pos,
                                                          input logic [2:0][31:0] vel);
      wall_force_type   res;
      wide_type         p, cut, gap_to_wall, zp, u, u2, u4, u5, q, r, perp, par;
      wide_type         a, b, c, factor, w, g;
      logic [2:0][31:0] force_v;
      logic             near;
      int               i;
      near = 1'b0;
      gap_to_wall = '0;
      force_v = '0;
      if (wall_axis != AXIS_NONE) begin
         p = wide_type'(q32_type'(pos[wall_axis]));
         cut = wide_type'(cutoff);
         if (p < wide_type'(left_wall) + cut) begin
            gap_to_wall = p - wide_type'(left_wall);
            near = 1'b1;
         end else if (p > wide_type'(right_wall) - cut) begin
            gap_to_wall = wide_type'(right_wall) - p;
            near = 1'b1;
         end
      end
      if (near) begin
         zp = round_mul(gap_to_wall, wide_type'(recip));
         if (zp > ONE_W) begin
            zp = ONE_W;
         end
         if (zp < -ONE_W) begin
            zp = -ONE_W;
         end
         u = ONE_W - zp;
         u2 = round_mul(u, u);
         u4 = round_mul(u2, u2);
         u5 = round_mul(u4, u);
         q = ONE_W + 4 * zp + 10 * round_mul(zp, zp);
         r = ONE_W + 2 * zp;
         perp = round_mul(u4, q);
         par = round_mul(u5, r);
         a = rounded_product_sat31(wide_type'(dissipation), wide_type'(density));
         b = rounded_product_sat31(wide_type'(cutoff), wide_type'(cutoff));
         c = rounded_product_sat31(a, b);
         factor = -(c / 12);
         for (i = 0; i < 3; i++) begin
            w = (i == int'(wall_axis)) ? perp : par;
            g = clamp_s32(round_mul(factor, w));
            force_v[i] = 32'(clamp_s32(round_mul(g, wide_type'(q32_type'(vel[i])))));
         end
      end
      res.in_band = near;
      res.force_x = force_v[0];
      res.force_y = force_v[1];
      res.force_z = force_v[2];
      return res;
   endfunction

   always @(posedge clock) begin : watch_channels
      wall_force_type want;
      if (reset) begin
         wall_axis = AXIS_X;
         left_wall = LEFT_WALL_RESET;
         right_wall = RIGHT_WALL_RESET;
         cutoff = ONE_RESET_31;
         recip = ONE_RESET_31;
         dissipation = ONE_RESET_31;
         density = ONE_RESET_31;
         expected_forces.delete();
         pending_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_forces.size() == 0) begin
               $error("result transfer with no particle outstanding");
               errors++;
            end else begin
               want = expected_forces.pop_front();
               if (rsp_in_band !== want.in_band) begin
                  $error("in_band: expected %0d, got %0d", want.in_band, rsp_in_band);
                  errors++;
               end
               if (rsp_force_x !== want.force_x) begin
                  $error("force_x: expected %h, got %h", want.force_x, rsp_force_x);
                  errors++;
               end
               if (rsp_force_y !== want.force_y) begin
                  $error("force_y: expected %h, got %h", want.force_y, rsp_force_y);
                  errors++;
               end
               if (rsp_force_z !== want.force_z) begin
                  $error("force_z: expected %h, got %h", want.force_z, rsp_force_z);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_forces.push_back(force_for_particle({req_pos_z, req_pos_y, req_pos_x},
                                                         {req_vel_z, req_vel_y, req_vel_x}));
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WALL_AXIS:         wall_axis = axis_type'(csr_wdata[1:0]);
               CSR_LEFT_WALL_POS:     left_wall = csr_wdata;
               CSR_RIGHT_WALL_POS:    right_wall = csr_wdata;
               CSR_CUTOFF_DIST:       cutoff = csr_wdata[30:0];
               CSR_RECIP_CUTOFF:      recip = csr_wdata[30:0];
               CSR_DISSIPATION_CONST: dissipation = csr_wdata[30:0];
               CSR_WALL_DENSITY:      density = csr_wdata[30:0];
               default: ;
            endcase
         end
         pending_count <= expected_forces.size();
      end
      mismatch_count <= errors;
   end

endmodule

[bench/dpd_wall_dissipative_force_unit_test.sv]
// Top of the wall force regression: clock, reset, particle stimulus, configuration and verdict.
module dpd_wall_dissipative_force_unit_test;
   import dpdw_pkg::*;

   localparam int     IDLE_LIMIT = 2000;
   localparam longint S32_HI = 64'sd2147483647;
   localparam longint S32_LO = -64'sd2147483648;
   localparam longint U31_HI = 64'sd2147483647;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_pos_x;
   logic [31:0] req_pos_y;
   logic [31:0] req_pos_z;
   logic [31:0] req_vel_x;
   logic [31:0] req_vel_y;
   logic [31:0] req_vel_z;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_in_band;
   logic [31:0] rsp_force_x;
   logic [31:0] rsp_force_y;
   logic [31:0] rsp_force_z;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;
   int          mismatch_count;
   int          pending_count;
   int          idle_cycles = 0;

   bit          send_quiet = 1'b0;
   bit          recv_quiet = 1'b0;
   axis_type    cur_axis = AXIS_X;
   longint      cur_left = -655360;
   longint      cur_right = 655360;
   longint      cur_cut = 65536;

   dpd_wall_dissipative_force_unit u_dut (.*);

   dpd_wall_dissipative_force_unit_check u_check (.*);

   always #10 clock = ~clock;

   function automatic longint clamp_s32(input longint v);
      longint s;
      s = v;
      if (v > S32_HI) begin
         s = S32_HI;
      end else if (v < S32_LO) begin
         s = S32_LO;
      end
      return s;
   endfunction

   // Coordinate along the wall axis, mostly placed inside or around a cutoff band.
   function automatic logic [31:0] wall_coordinate();
      longint span, v;
      span = (cur_cut >= 64'h2000_0000) ? 64'hFFFF_FFFF : 4 * cur_cut;
      case ($urandom_range(0, 11))
         0, 1, 2, 3: v = cur_left + longint'($urandom_range(0, 32'(span))) - span / 2;
         4, 5, 6, 7: v = cur_right + longint'($urandom_range(0, 32'(span))) - span / 2;
         8:          v = cur_left + cur_cut - longint'($urandom_range(0, 1));
         9:          v = cur_right - cur_cut + longint'($urandom_range(0, 1));
         default:    v = longint'(q32_type'($urandom));
      endcase
      return 32'(clamp_s32(v));
   endfunction

   function automatic logic [31:0] random_velocity();
      logic [31:0] v;
      if ($urandom_range(0, 3) == 0) begin
         v = 32'(longint'($urandom_range(0, 32'h0008_0000)) - 64'sh4_0000);
      end else begin
         v = $urandom;
      end
      return v;
   endfunction

   task automatic send_particle(input logic [31:0] px, py, pz, vx, vy, vz);
      int unsigned gap;
      gap = send_quiet ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      req_vel_x <= vx;
      req_vel_y <= vy;
      req_vel_z <= vz;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic pause_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic settle_pipeline();
      pause_for_results();
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_walls(input axis_type axis, input longint left, right, cut, recip,
                            diss, dens);
      write_reg(CSR_WALL_AXIS, 32'(axis));
      write_reg(CSR_LEFT_WALL_POS, 32'(left));
      write_reg(CSR_RIGHT_WALL_POS, 32'(right));
      write_reg(CSR_CUTOFF_DIST, 32'(cut));
      write_reg(CSR_RECIP_CUTOFF, 32'(recip));
      write_reg(CSR_DISSIPATION_CONST, 32'(diss));
      write_reg(CSR_WALL_DENSITY, 32'(dens));
      csr_wr_en <= 1'b0;
      cur_axis = axis;
      cur_left = left;
      cur_right = right;
      cur_cut = cut;
   endtask

   task automatic pick_random_walls(input int phase);
      axis_type axis;
      longint   center, half_gap, left, right, cut, recip, diss, dens;
      axis = axis_type'($urandom_range(0, 2));
      center = longint'($urandom_range(0, 32'h0040_0000)) - 64'sh20_0000;
      half_gap = longint'($urandom_range(0, 32'h0032_0000));
      cut = longint'($urandom_range(32'h0000_1000, 32'h0008_0000));
      recip = 64'h1_0000_0000 / cut;
      diss = longint'($urandom_range(0, 32'h0008_0000));
      dens = longint'($urandom_range(0, 32'h0004_0000));
      left = center - half_gap;
      right = center + half_gap;
      case (phase % 6)
         1: begin
            left = S32_LO;
            right = S32_HI;
            cut = U31_HI;
            recip = 1;
            diss = U31_HI;
            dens = U31_HI;
         end
         2: begin
            cut = 1;
            recip = U31_HI;
         end
         3: begin
            if (phase < 6) begin
               diss = 0;
            end else begin
               dens = 0;
            end
         end
         4: begin
            left = longint'(q32_type'($urandom));
            right = longint'(q32_type'($urandom));
            cut = longint'($urandom_range(1, 32'h7FFF_FFFF));
            recip = longint'($urandom_range(1, 32'h7FFF_FFFF));
            diss = longint'($urandom_range(0, 32'h7FFF_FFFF));
            dens = longint'($urandom_range(0, 32'h7FFF_FFFF));
         end
         5: begin
            // Crossed walls: the left wall lies to the right of the right wall.
            left = center + half_gap;
            right = center - half_gap;
         end
         default: ;
      endcase
      if (phase == 11) begin
         axis = AXIS_NONE;
      end
      set_walls(axis, left, right, cut, recip, diss, dens);
   endtask

   initial begin
      int unsigned hold;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         hold = recv_quiet ? 0 : $urandom_range(0, 11);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("dpd_wall_dissipative_force_unit regression: fail");
            $finish;
         end
      end
   end

   initial begin
      int               phase, n;
      logic [2:0][31:0] pos;
      req_valid <= 1'b0;
      req_pos_x <= '0;
      req_pos_y <= '0;
      req_pos_z <= '0;
      req_vel_x <= '0;
      req_vel_y <= '0;
      req_vel_z <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_WALL_AXIS;
      csr_wdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Configuration after reset: x axis, walls at -10 and +10, cutoff 1.0.
      send_particle(-622592, 7, 9, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
      send_particle(-589824, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_particle(-589825, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_particle(-655360, 0, 0, 32'h0003_0000, 32'hFFFD_0000, 32'h0001_0000);
      send_particle(32'h8000_0000, 1, 2, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_particle(589824, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_particle(589825, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_particle(655360, 0, 0, 32'hFFFF_0000, 32'h0002_0000, 32'h0001_0000);
      send_particle(32'h7FFF_FFFF, 3, 4, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_particle(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1, 2);
      send_particle(-655360, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_particle(-655360, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_particle(-640000, 0, 0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001);

      // Widest walls and cutoff with the largest constants drive the constant products to their limit.
      settle_pipeline();
      set_walls(AXIS_Y, S32_LO, S32_HI, U31_HI, 1, U31_HI, U31_HI);
      send_particle(5, 32'h8000_0000, 6, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
      send_particle(5, 32'h7FFF_FFFF, 6, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_particle(5, 32'hFFFF_FFFF, 6, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_particle(5, 32'hFFFF_FFFE, 6, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);

      // Smallest cutoff, largest reciprocal, no dissipation.
      settle_pipeline();
      set_walls(AXIS_Z, -655360, 655360, 1, U31_HI, 0, 65536);
      send_particle(1, 2, -655360, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_particle(1, 2, 655360, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);

      // No wall axis selected: nothing is ever near a wall.
      settle_pipeline();
      set_walls(AXIS_NONE, -655360, 655360, 65536, 65536, 65536, 65536);
      send_particle(-655360, -655360, -655360, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_particle($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);

      settle_pipeline();
      set_walls(AXIS_Z, -655360, 655360, 131072, 32768, 196608, 131072);
      send_particle(1, 2, -589824, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000);

      for (phase = 0; phase < 14; phase++) begin
         settle_pipeline();
         send_quiet = (phase % 4 == 1) || (phase % 4 == 3);
         recv_quiet = (phase % 4 >= 2);
         pick_random_walls(phase);
         for (n = 0; n < 120; n++) begin
            if ($urandom_range(0, 59) == 0) begin
               pause_for_results();
            end
            pos[0] = $urandom;
            pos[1] = $urandom;
            pos[2] = $urandom;
            if (cur_axis != AXIS_NONE) begin
               pos[cur_axis] = wall_coordinate();
            end
            send_particle(pos[0], pos[1], pos[2],
                          random_velocity(), random_velocity(), random_velocity());
         end
      end

      send_quiet = 1'b0;
      recv_quiet = 1'b0;
      settle_pipeline();
      if (mismatch_count == 0) begin
         $display("dpd_wall_dissipative_force_unit regression: pass");
      end else begin
         $display("dpd_wall_dissipative_force_unit regression: fail");
      end
      $finish;
   end

endmodule
